// ===== rtl/centroid_tracker_line_counter_defines.svh =====
// Assertion macros for the centroid tracker line counter.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CENTROID_TRACKER_LINE_COUNTER_DEFINES_SVH
`define CENTROID_TRACKER_LINE_COUNTER_DEFINES_SVH
// implication check, disabled during reset
`define CTLC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// next-cycle implication check, disabled during reset
`define CTLC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

// ===== rtl/ctlc_pkg.sv =====
// Shared types and constants for the centroid tracker line counter.
// No dependencies.
package ctlc_pkg;
   localparam int CoordW = 12;
   localparam int CentW  = 13;
   localparam int IdW    = 16;
   localparam int RadW   = 26;
   localparam int TotW   = 32;
   localparam int KeptW  = 6;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 26;

   localparam logic [CsrIdxW-1:0] CSR_LINE_SX = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_LINE_SY = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_LINE_EX = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_LINE_EY = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_RADIUS  = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [CoordW-1:0] box_x;
      logic [CoordW-1:0] box_y;
      logic [CoordW-1:0] box_w;
      logic [CoordW-1:0] box_h;
   } req_type;

   typedef struct packed {
      logic             frame_done;
      logic [IdW-1:0]   track_id;
      logic             new_track;
      logic             crossed_now;
      logic             dropped;
      logic [TotW-1:0]  total_crossings;
      logic [KeptW-1:0] tracks_kept;
   } rsp_type;

   typedef struct packed {
      logic [IdW-1:0]  id;
      logic [CentW-1:0] cx;
      logic [CentW-1:0] cy;
      logic             counted;
   } track_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_COPY, ST_READ, ST_SCAN, ST_X0, ST_X1, ST_X2, ST_X3, ST_X4,
      ST_X5, ST_X6, ST_FIN, ST_OUT
   } state_type;

   // multiply-accumulate ops for the shared unit
   typedef enum logic [1:0] {
      MAC_LOAD, MAC_ADD, MAC_SUB
   } mac_op_type;

   typedef struct packed {
      logic       en;
      mac_op_type op;
      logic signed [13:0] a;
      logic signed [13:0] b;
   } mac_ctl_type;
endpackage

// ===== rtl/ctlc_mac.sv =====
// Shared signed multiply-accumulate unit used for distances and cross products.
// Depends on ctlc_pkg.
module ctlc_mac (
   input  logic                  clock,
   input  ctlc_pkg::mac_ctl_type ctl,
   output logic signed [29:0]    acc
);
   logic signed [29:0] acc_ff, acc_in, prod;

   assign prod = 30'(ctl.a * ctl.b);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.en) begin
         unique case (ctl.op)
            ctlc_pkg::MAC_LOAD: acc_in = prod;
            ctlc_pkg::MAC_ADD:  acc_in = acc_ff + prod;
            ctlc_pkg::MAC_SUB:  acc_in = acc_ff - prod;
            default:            acc_in = prod;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule

// ===== rtl/centroid_tracker_line_counter.sv =====
// Centroid tracker with line-crossing counter, top level.
// Detection: stored tracks are compared one by one; the first within the radius gets the crossing test.
// End of frame: entries are copied one by one from the new table to the old one.
// One item at a time; a new input is stalled until the result has been taken.
// Synchronous active-high reset clears counts, ids and total and loads config defaults; tables are
// not cleared (entries beyond the counts are never read).
`include "centroid_tracker_line_counter_defines.svh"
module centroid_tracker_line_counter #(
   parameter int MAX_TRACKS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ctlc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ctlc_pkg::rsp_type                rsp_data,
   input  logic                             csr_write,
   input  logic [ctlc_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [ctlc_pkg::CsrDataW-1:0]    csr_wdata
);
   localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CW = $clog2(MAX_TRACKS + 1);

   ctlc_pkg::state_type state_ff, state_in;
   ctlc_pkg::track_type old_mem [MAX_TRACKS];
   ctlc_pkg::track_type new_mem [MAX_TRACKS];
   ctlc_pkg::track_type old_rd_ff, new_rd_ff;

   logic [CW-1:0] old_cnt_ff, old_cnt_in, new_cnt_ff, new_cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [ctlc_pkg::IdW-1:0] nid_ff, nid_in;
   logic [ctlc_pkg::TotW-1:0] tot_ff, tot_in;
   logic [11:0] lsx_ff, lsy_ff, lex_ff, ley_ff;
   logic [ctlc_pkg::RadW-1:0] rad_ff;
   logic [ctlc_pkg::CentW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [29:0] den_ff, den_in, tn_ff, tn_in;
   ctlc_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   ctlc_pkg::mac_ctl_type mac;
   logic signed [29:0] acc;

   logic old_we, new_we;
   logic [AW-1:0] old_wa, new_wa, old_ra, new_ra;
   ctlc_pkg::track_type old_wd, new_wd, upd;
   logic signed [13:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   logic tn_ok, un_ok;

   ctlc_mac u_mac (.clock(clock), .ctl(mac), .acc(acc));

   always_ff @(posedge clock) begin
      if (old_we) old_mem[old_wa] <= old_wd;
      if (new_we) new_mem[new_wa] <= new_wd;
      old_rd_ff <= old_mem[old_ra];
      new_rd_ff <= new_mem[new_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lsx_ff <= 12'd0;
         lsy_ff <= 12'd400;
         lex_ff <= 12'd900;
         ley_ff <= 12'd400;
         rad_ff <= 26'd6400;
      end else if (csr_write) begin
         unique case (csr_index)
            ctlc_pkg::CSR_LINE_SX: lsx_ff <= csr_wdata[11:0];
            ctlc_pkg::CSR_LINE_SY: lsy_ff <= csr_wdata[11:0];
            ctlc_pkg::CSR_LINE_EX: lex_ff <= csr_wdata[11:0];
            ctlc_pkg::CSR_LINE_EY: ley_ff <= csr_wdata[11:0];
            ctlc_pkg::CSR_RADIUS:  rad_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctlc_pkg::ST_IDLE;
         old_cnt_ff   <= '0;
         new_cnt_ff   <= '0;
         nid_ff       <= '0;
         tot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         old_cnt_ff   <= old_cnt_in;
         new_cnt_ff   <= new_cnt_in;
         nid_ff       <= nid_in;
         tot_ff       <= tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      den_ff <= den_in;
      tn_ff  <= tn_in;
      rsp_ff <= rsp_in;
   end

   // segment a = previous -> current centre, b = counting line
   assign ax1 = 14'(old_rd_ff.cx);
   assign ay1 = 14'(old_rd_ff.cy);
   assign ax2 = 14'(cx_ff);
   assign ay2 = 14'(cy_ff);
   assign bx1 = 14'(lsx_ff);
   assign by1 = 14'(lsy_ff);
   assign bx2 = 14'(lex_ff);
   assign by2 = 14'(ley_ff);

   assign tn_ok = (den_ff > 0) ? (tn_ff >= 0 && tn_ff <= den_ff)
                               : (tn_ff <= 0 && tn_ff >= den_ff);
   assign un_ok = (den_ff > 0) ? (acc >= 0 && acc <= den_ff)
                               : (acc <= 0 && acc >= den_ff);

   assign req_stall = (state_ff != ctlc_pkg::ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic [ctlc_pkg::KeptW-1:0] KeptWidth(input logic [CW-1:0] n);
      logic [CW+ctlc_pkg::KeptW-1:0] w;
      w = (CW+ctlc_pkg::KeptW)'(n);
      return w[ctlc_pkg::KeptW-1:0];
   endfunction

   always_comb begin
      state_in     = state_ff;
      old_cnt_in   = old_cnt_ff;
      new_cnt_in   = new_cnt_ff;
      nid_in       = nid_ff;
      tot_in       = tot_ff;
      idx_in       = idx_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      den_in       = den_ff;
      tn_in        = tn_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mac          = '{en: 1'b0, op: ctlc_pkg::MAC_LOAD, a: '0, b: '0};
      old_we = 1'b0;
      new_we = 1'b0;
      old_wa = idx_ff[AW-1:0];
      new_wa = new_cnt_ff[AW-1:0];
      old_wd = new_rd_ff;
      upd    = old_rd_ff;
      upd.cx = cx_ff;
      upd.cy = cy_ff;
      new_wd = upd;
      old_ra = idx_ff[AW-1:0];
      new_ra = idx_ff[AW-1:0];

      unique case (state_ff)
         ctlc_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               idx_in = '0;
               rsp_in = '0;
               cx_in  = 13'(req_data.box_x) + 13'(req_data.box_w[11:1]);
               cy_in  = 13'(req_data.box_y) + 13'(req_data.box_h[11:1]);
               state_in = req_data.operation ? ctlc_pkg::ST_COPY : ctlc_pkg::ST_READ;
            end
         end
         ctlc_pkg::ST_COPY: begin
            // new_rd_ff holds entry idx-1 read last cycle
            if (idx_ff != '0) begin
               old_we = 1'b1;
               old_wa = AW'(idx_ff - 1'b1);
            end
            if (idx_ff == new_cnt_ff) begin
               old_cnt_in = new_cnt_ff;
               new_cnt_in = '0;
               rsp_in.frame_done  = 1'b1;
               rsp_in.total_crossings = tot_ff;
               rsp_in.tracks_kept = KeptWidth(new_cnt_ff);
               state_in = ctlc_pkg::ST_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ctlc_pkg::ST_READ: begin
            if (idx_ff == old_cnt_ff) begin
               // no match: new track, or dropped when the new table is full
               rsp_in.track_id = nid_ff;
               if (new_cnt_ff < CW'(MAX_TRACKS)) begin
                  new_we = 1'b1;
                  new_wd = '{id: nid_ff, cx: cx_ff, cy: cy_ff, counted: 1'b0};
                  new_cnt_in = new_cnt_ff + 1'b1;
                  nid_in = nid_ff + 1'b1;
                  rsp_in.new_track = 1'b1;
                  rsp_in.tracks_kept = KeptWidth(new_cnt_ff + 1'b1);
               end else begin
                  rsp_in.dropped = 1'b1;
                  rsp_in.tracks_kept = KeptWidth(new_cnt_ff);
               end
               rsp_in.total_crossings = tot_ff;
               state_in = ctlc_pkg::ST_OUT;
            end else begin
               state_in = ctlc_pkg::ST_SCAN;
            end
         end
         ctlc_pkg::ST_SCAN: begin
            // accumulate dx*dx this cycle; dy*dy in X0
            mac = '{en: 1'b1, op: ctlc_pkg::MAC_LOAD,
                    a: ax1 - ax2, b: ax1 - ax2};
            state_in = ctlc_pkg::ST_X0;
         end
         ctlc_pkg::ST_X0: begin
            mac = '{en: 1'b1, op: ctlc_pkg::MAC_ADD, a: ay1 - ay2, b: ay1 - ay2};
            state_in = ctlc_pkg::ST_X1;
         end
         ctlc_pkg::ST_X1: begin
            if ({1'b0, acc} < {5'd0, rad_ff}) begin
               mac = '{en: 1'b1, op: ctlc_pkg::MAC_LOAD, a: ax1 - ax2, b: by1 - by2};
               state_in = ctlc_pkg::ST_X2;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ctlc_pkg::ST_READ;
            end
         end
         ctlc_pkg::ST_X2: begin
            mac = '{en: 1'b1, op: ctlc_pkg::MAC_SUB, a: ay1 - ay2, b: bx1 - bx2};
            state_in = ctlc_pkg::ST_X3;
         end
         ctlc_pkg::ST_X3: begin
            den_in = acc;
            mac = '{en: 1'b1, op: ctlc_pkg::MAC_LOAD, a: ax1 - bx1, b: by1 - by2};
            state_in = ctlc_pkg::ST_X4;
         end
         ctlc_pkg::ST_X4: begin
            mac = '{en: 1'b1, op: ctlc_pkg::MAC_SUB, a: ay1 - by1, b: bx1 - bx2};
            state_in = ctlc_pkg::ST_X5;
         end
         ctlc_pkg::ST_X5: begin
            tn_in = acc;
            mac = '{en: 1'b1, op: ctlc_pkg::MAC_LOAD, a: ax1 - bx1, b: ay1 - ay2};
            state_in = ctlc_pkg::ST_X6;
         end
         ctlc_pkg::ST_X6: begin
            mac = '{en: 1'b1, op: ctlc_pkg::MAC_SUB, a: ay1 - by1, b: ax1 - ax2};
            state_in = ctlc_pkg::ST_FIN;
         end
         ctlc_pkg::ST_FIN: begin
            if (!old_rd_ff.counted && den_ff != '0 && tn_ok && un_ok) begin
               upd.counted = 1'b1;
               rsp_in.crossed_now = 1'b1;
               if (tot_ff != '1) tot_in = tot_ff + 1'b1;
            end
            old_we = 1'b1;
            old_wd = upd;
            new_wd = upd;
            rsp_in.track_id = old_rd_ff.id;
            if (new_cnt_ff < CW'(MAX_TRACKS)) begin
               new_we = 1'b1;
               new_cnt_in = new_cnt_ff + 1'b1;
               rsp_in.tracks_kept = KeptWidth(new_cnt_ff + 1'b1);
            end else begin
               rsp_in.dropped = 1'b1;
               rsp_in.tracks_kept = KeptWidth(new_cnt_ff);
            end
            rsp_in.total_crossings = tot_in;
            state_in = ctlc_pkg::ST_OUT;
         end
         ctlc_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ctlc_pkg::ST_IDLE;
         end
         default: state_in = ctlc_pkg::ST_IDLE;
      endcase
   end

   `CTLC_ASSERT_IMP(a_new_bound, clock, reset, 1'b1, new_cnt_ff <= CW'(MAX_TRACKS))
   `CTLC_ASSERT_IMP(a_old_bound, clock, reset, 1'b1, old_cnt_ff <= CW'(MAX_TRACKS))
   `CTLC_ASSERT_IMP(a_stall_busy, clock, reset, state_ff != ctlc_pkg::ST_IDLE, req_stall)
   `CTLC_ASSERT_NXT(a_out_valid, clock, reset, state_ff == ctlc_pkg::ST_OUT, rsp_valid)
   `CTLC_ASSERT_NXT(a_tot_mono, clock, reset, 1'b1, tot_ff >= $past(tot_ff))
endmodule
